>>> src/uaip_pkg.sv
// ----------------------------------------------------------------------------
// uaip_pkg - shared types and codes for the FIG 0/13 parser
// Result kinds, parser phases and the result record passed between the
// parser and the top level.
// ----------------------------------------------------------------------------
package uaip_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_SERVICE   = 3'd0,
    KIND_APP       = 3'd1,
    KIND_APP_XPAD  = 3'd2,
    KIND_APP_CA    = 3'd3,
    KIND_DATA      = 3'd4,
    KIND_TRUNC     = 3'd5
  } kind_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_SID   = 4'd1,
    PH_SCIDS = 4'd2,
    PH_APP0  = 4'd3,
    PH_APP1  = 4'd4,
    PH_XPAD0 = 4'd5,
    PH_XPAD1 = 4'd6,
    PH_CA0   = 4'd7,
    PH_CA1   = 4'd8,
    PH_DATA  = 4'd9
  } phase_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [3:0]  sc_ids;
    logic [3:0]  num_apps;
    logic [10:0] app_type;
    logic [4:0]  app_data_length;
    logic        ca_applied;
    logic [4:0]  xpad_app_type;
    logic        data_groups_used;
    logic [5:0]  component_type;
    logic        truncated;
  } result_t;

endpackage

>>> src/uaip_fig_if.sv
// ----------------------------------------------------------------------------
// uaip_fig_if - FIG byte channel
// Valid/ready channel carrying one FIG byte with its framing flags.
// ----------------------------------------------------------------------------
interface uaip_fig_if;
  logic       valid;
  logic       ready;
  logic [7:0] fig_byte;
  logic       first;
  logic       last;
  logic       data_service;

  modport source (output valid, output fig_byte, output first, output last,
                  output data_service, input ready);
  modport sink   (input valid, input fig_byte, input first, input last,
                  input data_service, output ready);
endinterface

>>> src/uaip_res_if.sv
// ----------------------------------------------------------------------------
// uaip_res_if - parser result channel
// Valid/ready channel carrying one decoded FIG 0/13 result.
// ----------------------------------------------------------------------------
interface uaip_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [3:0]  sc_ids;
  logic [3:0]  num_apps;
  logic [10:0] app_type;
  logic [4:0]  app_data_length;
  logic        ca_applied;
  logic [4:0]  xpad_app_type;
  logic        data_groups_used;
  logic [5:0]  component_type;
  logic        truncated;

  modport source (output valid, output kind, output value, output sc_ids,
                  output num_apps, output app_type, output app_data_length,
                  output ca_applied, output xpad_app_type,
                  output data_groups_used, output component_type,
                  output truncated, input ready);
  modport sink   (input valid, input kind, input value, input sc_ids,
                  input num_apps, input app_type, input app_data_length,
                  input ca_applied, input xpad_app_type,
                  input data_groups_used, input component_type,
                  input truncated, output ready);
endinterface

>>> src/user_app_info_parser_core.sv
// ----------------------------------------------------------------------------
// user_app_info_parser_core - DAB FIG 0/13 user application info parser
// Takes the FIG body one byte per transfer on the fig channel, header byte
// first (marked by first, with the P/D flag on data_service) and the final
// byte marked by last. Results (service headers, application headers with
// optional X-PAD and CA organization, data bytes, truncation marks) leave
// on the res channel, at most one per input byte.
// Throughput: one byte per cycle unless the output stalls; parse state and
// result are registered as a byte is accepted, so a result is valid in the
// cycle after its byte. Bytes that give no result leave no gap.
// The output register is a single stage: fig.ready is high while it is
// empty or being drained, so while a result waits on a stalled receiver
// no byte is taken; input resumes in the cycle that result is taken.
// Reset (rst, synchronous) idles the parser until the next header byte
// and empties the output register.
// ----------------------------------------------------------------------------
module user_app_info_parser_core
  import uaip_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  uaip_fig_if.sink   fig,
  uaip_res_if.source res
);

  logic    take;
  logic    emit;
  result_t result;
  result_t res_reg;
  logic    res_valid;

  // Input transfer whenever the result stage is free or draining
  assign fig.ready = !res_valid || res.ready;
  assign take      = fig.valid && fig.ready;

  uaip_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .fig_byte     (fig.fig_byte),
    .first        (fig.first),
    .last         (fig.last),
    .data_service (fig.data_service),
    .emit         (emit),
    .result       (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_reg <= result;
    end
  end

  assign res.valid            = res_valid;
  assign res.kind             = res_reg.kind;
  assign res.value            = res_reg.value;
  assign res.sc_ids           = res_reg.sc_ids;
  assign res.num_apps         = res_reg.num_apps;
  assign res.app_type         = res_reg.app_type;
  assign res.app_data_length  = res_reg.app_data_length;
  assign res.ca_applied       = res_reg.ca_applied;
  assign res.xpad_app_type    = res_reg.xpad_app_type;
  assign res.data_groups_used = res_reg.data_groups_used;
  assign res.component_type   = res_reg.component_type;
  assign res.truncated        = res_reg.truncated;

endmodule

>>> src/uaip_parser.sv
// ----------------------------------------------------------------------------
// uaip_parser - FIG 0/13 byte parser state machine
// Holds the parse state; on each accepted byte it advances the state and
// offers at most one result for the output register.
// ----------------------------------------------------------------------------
module uaip_parser
  import uaip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] fig_byte,
  input  logic       first,
  input  logic       last,
  input  logic       data_service,
  output logic       emit,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [1:0]  byte_count, byte_count_next;
  logic        is_data_service, is_data_service_next;
  logic [31:0] assembled_id, assembled_id_next;
  logic [3:0]  apps_left, apps_left_next;
  logic [4:0]  data_left, data_left_next;
  logic [23:0] held_fields, held_fields_next;  // type, ca, xpad, dg, comp
  logic        ca_org_flag, ca_org_flag_next;

  logic [4:0]  len;
  logic        trunc;
  logic        do_end;

  // Phase that follows a finished item
  function automatic phase_t after_item(input logic [4:0] dl, input logic [3:0] al);
    phase_t p;
    if (dl != 5'd0) begin
      p = PH_DATA;
    end else if (al != 4'd0) begin
      p = PH_APP0;
    end else begin
      p = PH_SID;
    end
    return p;
  endfunction

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      is_data_service <= 1'b0;
      assembled_id    <= '0;
      apps_left       <= '0;
      data_left       <= '0;
      held_fields     <= '0;
      ca_org_flag     <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      is_data_service <= is_data_service_next;
      assembled_id    <= assembled_id_next;
      apps_left       <= apps_left_next;
      data_left       <= data_left_next;
      held_fields     <= held_fields_next;
      ca_org_flag     <= ca_org_flag_next;
    end
  end

  // Next state and result
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    is_data_service_next = is_data_service;
    assembled_id_next    = assembled_id;
    apps_left_next       = apps_left;
    data_left_next       = data_left;
    held_fields_next     = held_fields;
    ca_org_flag_next     = ca_org_flag;
    emit                 = 1'b0;
    result               = '0;
    len                  = '0;
    trunc                = 1'b0;
    do_end               = 1'b0;

    if (first) begin
      // header byte: restart, latch P/D
      phase_next           = last ? PH_IDLE : PH_SID;
      byte_count_next      = '0;
      is_data_service_next = data_service;
      assembled_id_next    = '0;
      apps_left_next       = '0;
      data_left_next       = '0;
      held_fields_next     = '0;
      ca_org_flag_next     = 1'b0;
    end else if (phase != PH_IDLE) begin
      do_end = last;
      case (phase)
        PH_SID: begin
          if (byte_count == 2'd0) begin
            assembled_id_next = {24'd0, fig_byte};
          end else begin
            assembled_id_next = {assembled_id[23:0], fig_byte};
          end
          if (byte_count == (is_data_service ? 2'd3 : 2'd1)) begin
            byte_count_next = '0;
            phase_next      = PH_SCIDS;
          end else begin
            byte_count_next = byte_count + 2'd1;
          end
        end
        PH_SCIDS: begin
          emit            = 1'b1;
          result.kind     = KIND_SERVICE;
          result.value    = assembled_id;
          result.sc_ids   = fig_byte[7:4];
          result.num_apps = fig_byte[3:0];
          apps_left_next  = fig_byte[3:0];
          data_left_next  = '0;
          phase_next      = after_item(5'd0, fig_byte[3:0]);
        end
        PH_APP0: begin
          held_fields_next = {13'd0, fig_byte, 3'd0};
          phase_next       = PH_APP1;
        end
        PH_APP1: begin
          held_fields_next = {13'd0, held_fields[10:3], fig_byte[7:5]};
          len              = fig_byte[4:0];
          apps_left_next   = apps_left - 4'd1;
          data_left_next   = len;
          if (!is_data_service && len >= 5'd2) begin
            phase_next = PH_XPAD0;
          end else begin
            emit                   = 1'b1;
            result.kind            = KIND_APP;
            result.app_type        = held_fields_next[10:0];
            result.app_data_length = len;
            phase_next             = after_item(len, apps_left_next);
          end
        end
        PH_XPAD0: begin
          ca_org_flag_next = fig_byte[6];
          held_fields_next = {7'd0, fig_byte[4:0], fig_byte[7], held_fields[10:0]};
          phase_next       = PH_XPAD1;
        end
        PH_XPAD1: begin
          held_fields_next = {fig_byte[5:0], ~fig_byte[7], held_fields[16:0]};
          len = (data_left >= 5'd2) ? data_left - 5'd2 : 5'd0;
          if (ca_org_flag) begin
            data_left_next = (len >= 5'd2) ? len - 5'd2 : 5'd0;
            phase_next     = PH_CA0;
          end else begin
            data_left_next          = len;
            emit                    = 1'b1;
            result.kind             = KIND_APP_XPAD;
            result.app_type         = held_fields_next[10:0];
            result.app_data_length  = len;
            result.ca_applied       = held_fields_next[11];
            result.xpad_app_type    = held_fields_next[16:12];
            result.data_groups_used = held_fields_next[17];
            result.component_type   = held_fields_next[23:18];
            phase_next              = after_item(len, apps_left);
          end
        end
        PH_CA0: begin
          assembled_id_next = {24'd0, fig_byte};
          phase_next        = PH_CA1;
        end
        PH_CA1: begin
          assembled_id_next       = {16'd0, assembled_id[7:0], fig_byte};
          emit                    = 1'b1;
          result.kind             = KIND_APP_CA;
          result.value            = assembled_id_next;
          result.app_type         = held_fields[10:0];
          result.app_data_length  = data_left;
          result.ca_applied       = held_fields[11];
          result.xpad_app_type    = held_fields[16:12];
          result.data_groups_used = held_fields[17];
          result.component_type   = held_fields[23:18];
          phase_next              = after_item(data_left, apps_left);
        end
        PH_DATA: begin
          emit           = 1'b1;
          result.kind    = KIND_DATA;
          result.value   = {24'd0, fig_byte};
          data_left_next = data_left - 5'd1;
          phase_next     = after_item(data_left_next, apps_left);
        end
        default: begin
          phase_next = PH_IDLE;
          do_end     = 1'b0;
        end
      endcase

      // entering a new service id starts the count afresh
      if (phase_next == PH_SID && phase != PH_SID) begin
        byte_count_next = '0;
      end

      // final byte: go idle, flag an unfinished entry
      if (do_end) begin
        trunc      = !(phase_next == PH_SID && byte_count_next == 2'd0);
        phase_next = PH_IDLE;
        if (emit) begin
          result.truncated = trunc;
        end else if (trunc) begin
          emit             = 1'b1;
          result.kind      = KIND_TRUNC;
          result.truncated = 1'b1;
        end
      end
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the FIG 0/13 user application info parser
// Drives FIG bytes into the fig channel and holds its own model of the
// parser. Every accepted byte updates that model and may queue one expected
// result. The res channel monitor compares each transfer field by field
// against the oldest queued result. Directed FIGs cover the corner cases.
// Random FIGs follow: mostly well-formed, some cut short, some corrupted,
// some restarted by a header in mid-FIG, and some with stray bytes.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb
  import uaip_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned MAX_REPORTS  = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uaip_fig_if fig ();
  uaip_res_if res ();

  user_app_info_parser_core u_top (
    .clk (clk),
    .rst (rst),
    .fig (fig),
    .res (res)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser model state
  phase_t      p_phase    = PH_IDLE;
  logic [1:0]  p_cnt      = '0;
  logic        p_data_svc = 1'b0;
  logic [31:0] p_id       = '0;
  logic [3:0]  p_apps     = '0;
  logic [4:0]  p_left     = '0;
  logic [31:0] p_held     = '0;
  logic        p_ca_org   = 1'b0;

  result_t     pending_results[$];
  logic [7:0]  fig_body[$];

  int unsigned error_count  = 0;
  int unsigned parsed_bytes = 0;
  int unsigned fig_count    = 0;
  int unsigned result_count = 0;
  int unsigned kind_seen[6] = '{default: 0};
  int unsigned cycle_count  = 0;
  bit          src_gaps     = 1'b1;
  bit          sink_stalls  = 1'b1;

  // Mismatch reporting
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Add one byte to the end of the FIG body
  task automatic add_body_byte(input logic [7:0] b);
    fig_body = {fig_body, b};
  endtask

  // Model: move on once a service header, application header or data byte is finished
  task automatic next_field();
    if (p_left != 5'd0) begin
      p_phase = PH_DATA;
    end else if (p_apps != 4'd0) begin
      p_phase = PH_APP0;
    end else begin
      p_phase = PH_SID;
      p_cnt   = 2'd0;
    end
  endtask

  function automatic result_t app_fields(input result_t r, input logic with_xpad);
    result_t o;
    o = r;
    o.app_type        = p_held[10:0];
    o.app_data_length = p_left;
    if (with_xpad) begin
      o.ca_applied       = p_held[11];
      o.xpad_app_type    = p_held[16:12];
      o.data_groups_used = p_held[17];
      o.component_type   = p_held[23:18];
    end
    return o;
  endfunction

  // Model: one accepted byte, queues the result it should cause
  task automatic predict_fig_byte(input logic [7:0] b, input logic is_first,
                                  input logic is_last, input logic ds);
    result_t    r;
    logic       emit;
    logic       trunc;
    logic [4:0] len;
    r    = '0;
    emit = 1'b0;
    if (is_first) begin
      parsed_bytes++;
      p_cnt      = '0;
      p_id       = '0;
      p_apps     = '0;
      p_left     = '0;
      p_held     = '0;
      p_ca_org   = 1'b0;
      p_data_svc = ds;
      p_phase    = is_last ? PH_IDLE : PH_SID;
      return;
    end
    if (p_phase == PH_IDLE)
      return;
    parsed_bytes++;

    case (p_phase)
      PH_SID: begin
        p_id = (p_cnt == 2'd0) ? {24'd0, b} : {p_id[23:0], b};
        if (p_cnt == (p_data_svc ? 2'd3 : 2'd1)) begin
          p_cnt   = 2'd0;
          p_phase = PH_SCIDS;
        end else begin
          p_cnt = p_cnt + 2'd1;
        end
      end
      PH_SCIDS: begin
        r.kind     = KIND_SERVICE;
        r.value    = p_id;
        r.sc_ids   = b[7:4];
        r.num_apps = b[3:0];
        emit       = 1'b1;
        p_apps     = b[3:0];
        p_left     = 5'd0;
        next_field();
      end
      PH_APP0: begin
        p_held  = {21'd0, b, 3'd0};
        p_phase = PH_APP1;
      end
      PH_APP1: begin
        p_held = {21'd0, p_held[10:3], b[7:5]};
        len    = b[4:0];
        p_apps = p_apps - 4'd1;
        p_left = len;
        if (!p_data_svc && len >= 5'd2) begin
          p_phase = PH_XPAD0;
        end else begin
          r.kind = KIND_APP;
          r      = app_fields(r, 1'b0);
          emit   = 1'b1;
          next_field();
        end
      end
      PH_XPAD0: begin
        p_ca_org = b[6];
        p_held   = {15'd0, b[4:0], b[7], p_held[10:0]};
        p_phase  = PH_XPAD1;
      end
      PH_XPAD1: begin
        // DG bit is inverted; lengths never wrap below zero
        p_held = {8'd0, b[5:0], ~b[7], p_held[16:0]};
        len    = (p_left >= 5'd2) ? p_left - 5'd2 : 5'd0;
        if (p_ca_org) begin
          p_left  = (len >= 5'd2) ? len - 5'd2 : 5'd0;
          p_phase = PH_CA0;
        end else begin
          p_left = len;
          r.kind = KIND_APP_XPAD;
          r      = app_fields(r, 1'b1);
          emit   = 1'b1;
          next_field();
        end
      end
      PH_CA0: begin
        p_id    = {24'd0, b};
        p_phase = PH_CA1;
      end
      PH_CA1: begin
        p_id    = {16'd0, p_id[7:0], b};
        r.kind  = KIND_APP_CA;
        r.value = p_id;
        r       = app_fields(r, 1'b1);
        emit    = 1'b1;
        next_field();
      end
      PH_DATA: begin
        r.kind  = KIND_DATA;
        r.value = {24'd0, b};
        emit    = 1'b1;
        p_left  = p_left - 5'd1;
        next_field();
      end
      default: begin
        p_phase = PH_IDLE;
        return;
      end
    endcase

    // End of FIG: flag an unfinished entry
    if (is_last) begin
      trunc   = !(p_phase == PH_SID && p_cnt == 2'd0);
      p_phase = PH_IDLE;
      if (emit) begin
        r.truncated = trunc;
      end else if (trunc) begin
        r.kind      = KIND_TRUNC;
        r.truncated = 1'b1;
        emit        = 1'b1;
      end
    end
    if (emit)
      pending_results = {pending_results, r};
  endtask

  // Send one byte; predicts it at the edge where the transfer happens
  task automatic send_byte(input logic [7:0] b, input logic is_first,
                           input logic is_last, input logic ds);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 99) < 25) begin
      gap = draw_gap();
      fig.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fig.valid        <= 1'b1;
    fig.fig_byte     <= b;
    fig.first        <= is_first;
    fig.last         <= is_last;
    fig.data_service <= ds;
    @(posedge clk);
    while (!fig.ready) @(posedge clk);
    predict_fig_byte(b, is_first, is_last, ds);
  endtask

  // Hold the sender until every queued result has come back
  task automatic wait_drained();
    fig.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        res.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 99) < 15) begin
        hold = draw_gap() - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d value %0h",
                                  res.kind, res.value));
      end else begin
        want = pending_results.pop_front();
        if (want.kind <= KIND_TRUNC)
          kind_seen[want.kind]++;
        if (res.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d exp %0d", res.kind, want.kind));
        if (res.value !== want.value)
          report_mismatch($sformatf("value got %0h exp %0h", res.value, want.value));
        if (res.sc_ids !== want.sc_ids)
          report_mismatch($sformatf("sc_ids got %0h exp %0h", res.sc_ids, want.sc_ids));
        if (res.num_apps !== want.num_apps)
          report_mismatch($sformatf("num_apps got %0d exp %0d",
                                    res.num_apps, want.num_apps));
        if (res.app_type !== want.app_type)
          report_mismatch($sformatf("app_type got %0h exp %0h",
                                    res.app_type, want.app_type));
        if (res.app_data_length !== want.app_data_length)
          report_mismatch($sformatf("app_data_length got %0d exp %0d",
                                    res.app_data_length, want.app_data_length));
        if (res.ca_applied !== want.ca_applied)
          report_mismatch($sformatf("ca_applied got %0b exp %0b",
                                    res.ca_applied, want.ca_applied));
        if (res.xpad_app_type !== want.xpad_app_type)
          report_mismatch($sformatf("xpad_app_type got %0h exp %0h",
                                    res.xpad_app_type, want.xpad_app_type));
        if (res.data_groups_used !== want.data_groups_used)
          report_mismatch($sformatf("data_groups_used got %0b exp %0b",
                                    res.data_groups_used, want.data_groups_used));
        if (res.component_type !== want.component_type)
          report_mismatch($sformatf("component_type got %0h exp %0h",
                                    res.component_type, want.component_type));
        if (res.truncated !== want.truncated)
          report_mismatch($sformatf("truncated got %0b exp %0b",
                                    res.truncated, want.truncated));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stray bytes before any header, an empty FIG, and a stray byte after it
  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0, 1'b0);
  endtask

  // Programme service: plain app, app with X-PAD, app with CA org and
  // a length that would underflow; the CA word ends the FIG cleanly
  task automatic test_programme_service();
    fig_count++;
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hF3, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hE1, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0, 1'b0);
    send_byte(8'h43, 1'b0, 1'b0, 1'b0);
    send_byte(8'h40, 1'b0, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0, 1'b0);
    send_byte(8'hCD, 1'b0, 1'b1, 1'b0);
  endtask

  // Data service: 32-bit ids, an entry with no apps, a long app cut
  // short on a data byte, then a FIG that ends inside a service id
  task automatic test_data_service();
    fig_count += 2;
    send_byte(8'h80, 1'b1, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0, 1'b0);
    send_byte(8'h50, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0, 1'b0);
    send_byte(8'h5F, 1'b0, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b1, 1'b1);
  endtask

  // Append one well-formed entry to the FIG body
  task automatic append_entry(input logic ds);
    logic [3:0] apps;
    logic [4:0] len;
    logic [7:0] x0;
    int         n_data;
    repeat (ds ? 4 : 2) add_body_byte(8'($urandom));
    apps = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                       : 4'($urandom_range(0, 3));
    add_body_byte({4'($urandom_range(0, 15)), apps});
    repeat (apps) begin
      len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(7, 31))
                                        : 5'($urandom_range(0, 6));
      add_body_byte(8'($urandom));
      add_body_byte({3'($urandom_range(0, 7)), len});
      n_data = len;
      if (!ds && len >= 5'd2) begin
        x0 = 8'($urandom);
        add_body_byte(x0);
        add_body_byte(8'($urandom));
        n_data = len - 2;
        if (x0[6]) begin
          add_body_byte(8'($urandom));
          add_body_byte(8'($urandom));
          n_data = (n_data >= 2) ? n_data - 2 : 0;
        end
      end
      repeat (n_data) add_body_byte(8'($urandom));
    end
  endtask

  // Random FIGs, mostly well-formed, with cut, corrupted and restarted ones
  task automatic test_random_figs();
    int unsigned target;
    int unsigned figs;
    int unsigned mode;
    int unsigned cut;
    logic        ds;
    logic        end_flag;
    target = parsed_bytes + RANDOM_ITEMS;
    figs   = 0;
    while (parsed_bytes < target) begin
      // switch idling style now and then, including none at all
      if (figs % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: begin src_gaps = 1'b1; sink_stalls = 1'b1; end
          1: begin src_gaps = 1'b1; sink_stalls = 1'b0; end
          2: begin src_gaps = 1'b0; sink_stalls = 1'b1; end
          default: begin src_gaps = 1'b0; sink_stalls = 1'b0; end
        endcase
      end
      if (figs % 25 == 24)
        wait_drained();

      ds = 1'($urandom_range(0, 1));
      fig_body.delete();
      repeat ($urandom_range(1, 3)) append_entry(ds);
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
        // cut short anywhere, possibly down to the header alone
        cut = $urandom_range(0, fig_body.size() - 1);
        while (fig_body.size() > cut)
          void'(fig_body.pop_back());
      end else if (mode < 15) begin
        // corrupt one byte
        fig_body[$urandom_range(0, fig_body.size() - 1)] = 8'($urandom);
      end
      // a FIG without last is broken off by the next header
      end_flag = !(mode >= 15 && mode < 20);

      send_byte(8'($urandom), 1'b1, end_flag && fig_body.size() == 0, ds);
      foreach (fig_body[i])
        send_byte(fig_body[i], 1'b0, end_flag && i == fig_body.size() - 1,
                  1'($urandom_range(0, 1)));
      if (mode >= 20 && mode < 25 && end_flag)
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      figs++;
      fig_count++;
    end
  endtask

  // Test sequence
  initial begin
    fig.valid        <= 1'b0;
    fig.fig_byte     <= '0;
    fig.first        <= 1'b0;
    fig.last         <= 1'b0;
    fig.data_service <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_bytes();
    test_programme_service();
    wait_drained();
    test_data_service();
    wait_drained();
    test_random_figs();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Parsed %0d bytes in %0d FIGs (programme and data services, cut, corrupted,",
             parsed_bytes, fig_count);
    $display("restarted); results %0d: svc %0d app %0d xpad %0d ca %0d data %0d trunc %0d",
             result_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5]);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/uaip_pkg.sv
src/uaip_fig_if.sv
src/uaip_res_if.sv
src/uaip_parser.sv
src/user_app_info_parser_core.sv
test/tb.sv
